// ===== sv/vertex_order_cost_evaluator_core_defines.svh =====
// Assertion helpers shared by the controller and the datapath.
// Both expect clk and rst_n in scope.
`ifndef VERTEX_ORDER_COST_EVALUATOR_CORE_DEFINES_SVH
`define VERTEX_ORDER_COST_EVALUATOR_CORE_DEFINES_SVH

// Same-cycle implication.
`define VOCE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define VOCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/voce_pkg.sv =====
`default_nettype none

package voce_pkg;

  // Field widths
  localparam int MODE_W   = 1;
  localparam int VERTEX_W = 5;
  localparam int SLOT_W   = 4;
  localparam int MASK_W   = 32;
  localparam int COST_W   = 32;
  localparam int SUM_W    = 40;

  // Parameter defaults
  localparam int MAX_VERTICES_DEF = 32;
  localparam int MAX_SETS_DEF     = 16;

  // Mode codes
  localparam logic [MODE_W-1:0] MODE_LOAD  = 1'b0;
  localparam logic [MODE_W-1:0] MODE_ORDER = 1'b1;

  // One candidate parent set as kept in the table
  typedef struct packed {
    logic              valid;
    logic [MASK_W-1:0] mask;
    logic [COST_W-1:0] cost;
  } voce_entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } voce_state_t;

  // Controller -> datapath
  typedef struct packed {
    logic clear;    // write one invalid entry of the sweep
    logic take;     // input beat accepted
    logic scan_rd;  // read the next slot of the current vertex
    logic finish;   // fold best cost into the sum and mark vertex seen, or post the total and clear on the last vertex
  } voce_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic clear_done;
    logic in_order;
    logic in_range;
    logic scan_last;
    logic last;
    logic out_full;
  } voce_sts_t;

endpackage

`default_nettype wire

// ===== sv/voce_if.sv =====
`default_nettype none

interface voce_in_if;
  import voce_pkg::*;

  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [VERTEX_W-1:0] vertex;
  logic [SLOT_W-1:0]   slot;
  logic [MASK_W-1:0]   parent_mask;
  logic [COST_W-1:0]   set_cost;
  logic                entry_valid;
  logic                last_in_order;

  modport source (
    output valid, mode, vertex, slot, parent_mask, set_cost, entry_valid, last_in_order,
    input  ready
  );
  modport sink (
    input  valid, mode, vertex, slot, parent_mask, set_cost, entry_valid, last_in_order,
    output ready
  );
endinterface

interface voce_out_if;
  import voce_pkg::*;

  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] total_cost;

  modport source (output valid, total_cost, input ready);
  modport sink   (input valid, total_cost, output ready);
endinterface

`default_nettype wire

// ===== sv/voce_dp.sv =====
`default_nettype none

`include "vertex_order_cost_evaluator_core_defines.svh"

module voce_dp #(
  parameter int MAX_VERTICES = voce_pkg::MAX_VERTICES_DEF,
  parameter int MAX_SETS     = voce_pkg::MAX_SETS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire voce_pkg::voce_cmd_t           cmd,
  output voce_pkg::voce_sts_t                sts,
  input  wire logic [voce_pkg::MODE_W-1:0]   in_mode,
  input  wire logic [voce_pkg::VERTEX_W-1:0] in_vertex,
  input  wire logic [voce_pkg::SLOT_W-1:0]   in_slot,
  input  wire logic [voce_pkg::MASK_W-1:0]   in_parent_mask,
  input  wire logic [voce_pkg::COST_W-1:0]   in_set_cost,
  input  wire logic                          in_entry_valid,
  input  wire logic                          in_last_in_order,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [voce_pkg::SUM_W-1:0]         out_total_cost
);
  import voce_pkg::*;

  localparam int TD = MAX_VERTICES * MAX_SETS;
  localparam int AW = $clog2(TD);
  localparam int CW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam logic [AW-1:0] CLR_LAST  = AW'(TD - 1);
  localparam logic [CW-1:0] SLOT_LAST = CW'(MAX_SETS - 1);

  // Candidate table
  voce_entry_t mem [TD];
  voce_entry_t mem_q_r;
  voce_entry_t mem_wd;
  logic [AW-1:0] mem_wa;
  logic          mem_we;

  logic [AW-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic [AW-1:0]       base_r, base_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [VERTEX_W-1:0] vtx_r, vtx_nxt;
  logic                last_r, last_nxt;
  logic                rd_v_r, rd_v_nxt;
  logic                found_r, found_nxt;
  logic [COST_W-1:0]   best_r, best_nxt;
  logic [MASK_W-1:0]   seen_r, seen_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0]    out_total_r, out_total_nxt;

  logic [AW-1:0]  ld_addr;
  logic [AW-1:0]  rd_addr;
  logic           in_vtx_ok;
  logic           in_slot_ok;
  logic           qual;
  logic [SUM_W:0] sum_add;
  logic [SUM_W-1:0] sum_sat;

  assign in_vtx_ok  = 32'(in_vertex) < 32'(MAX_VERTICES);
  assign in_slot_ok = 32'(in_slot) < 32'(MAX_SETS);
  assign ld_addr    = AW'(32'(in_vertex) * 32'(MAX_SETS) + 32'(in_slot));
  assign rd_addr    = base_r + AW'(cnt_r);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = ld_addr;
    mem_wd = '{valid: in_entry_valid, mask: in_parent_mask, cost: in_set_cost};
    if (cmd.clear) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt_r;
      mem_wd = '0;
    end else if (cmd.take && in_mode == MODE_LOAD && in_vtx_ok && in_slot_ok) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q_r <= mem[rd_addr];
  end

  // A slot qualifies when it is valid and all its parents are already seen
  assign qual = rd_v_r && mem_q_r.valid && ((mem_q_r.mask & ~seen_r) == '0);

  assign sum_add = {1'b0, sum_r} + (SUM_W + 1)'(found_r ? best_r : '0);
  assign sum_sat = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];

  always_comb begin
    clr_cnt_nxt   = clr_cnt_r;
    base_nxt      = base_r;
    cnt_nxt       = cnt_r;
    vtx_nxt       = vtx_r;
    last_nxt      = last_r;
    rd_v_nxt      = cmd.scan_rd;
    found_nxt     = found_r;
    best_nxt      = best_r;
    seen_nxt      = seen_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r;
    out_total_nxt = out_total_r;

    if (cmd.clear) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
    end

    if (cmd.take && in_mode == MODE_ORDER) begin
      vtx_nxt   = in_vertex;
      last_nxt  = in_last_in_order;
      base_nxt  = AW'(32'(in_vertex) * 32'(MAX_SETS));
      cnt_nxt   = '0;
      found_nxt = 1'b0;
    end

    if (cmd.scan_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end

    if (qual && (!found_r || mem_q_r.cost < best_r)) begin
      best_nxt  = mem_q_r.cost;
      found_nxt = 1'b1;
    end

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cmd.finish) begin
      if (last_r) begin
        out_valid_nxt = 1'b1;
        out_total_nxt = sum_sat;
        sum_nxt       = '0;
        seen_nxt      = '0;
      end else begin
        sum_nxt  = sum_sat;
        seen_nxt = seen_r | (MASK_W'(1) << vtx_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      rd_v_r      <= 1'b0;
      found_r     <= 1'b0;
      seen_r      <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
      last_r      <= 1'b0;
    end else begin
      clr_cnt_r   <= clr_cnt_nxt;
      rd_v_r      <= rd_v_nxt;
      found_r     <= found_nxt;
      seen_r      <= seen_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
      last_r      <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r      <= base_nxt;
    cnt_r       <= cnt_nxt;
    vtx_r       <= vtx_nxt;
    best_r      <= best_nxt;
    out_total_r <= out_total_nxt;
  end

  always_comb begin
    sts.clear_done = clr_cnt_r == CLR_LAST;
    sts.in_order   = in_mode == MODE_ORDER;
    sts.in_range   = in_vtx_ok;
    sts.scan_last  = cnt_r == SLOT_LAST;
    sts.last       = last_r;
    sts.out_full   = out_valid_r && !out_ready;
  end

  assign out_valid      = out_valid_r;
  assign out_total_cost = out_total_r;

  `VOCE_ASSERT_NEXT(a_result_posted, cmd.finish && last_r, out_valid_r, "result not posted")
  `VOCE_ASSERT_NEXT(a_sum_cleared, cmd.finish && last_r, sum_r == '0 && seen_r == '0, "sum not cleared")
  `VOCE_ASSERT_NEXT(a_vertex_seen, cmd.finish && !last_r, seen_r[$past(vtx_r)] && sum_r >= $past(sum_r), "vertex not marked or sum shrank")

endmodule

`default_nettype wire

// ===== sv/voce_ctrl.sv =====
`default_nettype none

`include "vertex_order_cost_evaluator_core_defines.svh"

module voce_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire voce_pkg::voce_sts_t sts,
  output voce_pkg::voce_cmd_t      cmd
);
  import voce_pkg::*;

  voce_state_t state_r, state_nxt;
  logic        accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
        if (in_valid && sts.in_order) begin
          state_nxt = sts.in_range ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        // hold a last vertex while a finished total still sits unclaimed
        if (!sts.last || !sts.out_full) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  `VOCE_ASSERT_NEXT(a_scan_start, accept && sts.in_order && sts.in_range, state_r == ST_SCAN, "scan did not start")
  `VOCE_ASSERT_NEXT(a_scan_end, state_r == ST_SCAN && sts.scan_last, state_r == ST_DRAIN, "scan overran")
  `VOCE_ASSERT_NEXT(a_finish_hold, state_r == ST_FINISH && sts.last && sts.out_full, state_r == ST_FINISH, "total dropped")

endmodule

`default_nettype wire

// ===== sv/vertex_order_cost_evaluator_core.sv =====
// Channel   Dir  Handshake        Beat contents
// in_ch     in   valid / ready    mode, vertex, slot, parent_mask, set_cost,
//                                 entry_valid, last_in_order
// out_ch    out  valid / ready    total_cost (24.16 unsigned)
//
// Load beat (mode 0): written straight into the table if in range.
// Ordering beat (mode 1): the vertex's slots are read one per cycle from
//   the table, a drain state covers the registered read, and a finish
//   state folds the best cost into the saturating sum.
// After reset a sweep over the MAX_VERTICES * MAX_SETS entries marks every
//   table entry invalid; in_ch.ready stays low until it completes.
// A total waits in the output register; the next ordering beats still go
//   through, and only a further last vertex stalls until out_ch is drained.
`default_nettype none

module vertex_order_cost_evaluator_core #(
  parameter int MAX_VERTICES = voce_pkg::MAX_VERTICES_DEF,  // 2 .. 32
  parameter int MAX_SETS     = voce_pkg::MAX_SETS_DEF       // 1 .. 16
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  voce_in_if.sink     in_ch,
  voce_out_if.source  out_ch
);
  import voce_pkg::*;

  voce_cmd_t cmd;   // sequencing from the controller
  voce_sts_t sts;   // datapath conditions back to it

  // Controller: clear sweep, per-vertex slot scan, finish handshake
  voce_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: candidate table, min-cost search, seen mask, running sum
  voce_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_SETS     (MAX_SETS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_mode          (in_ch.mode),
    .in_vertex        (in_ch.vertex),
    .in_slot          (in_ch.slot),
    .in_parent_mask   (in_ch.parent_mask),
    .in_set_cost      (in_ch.set_cost),
    .in_entry_valid   (in_ch.entry_valid),
    .in_last_in_order (in_ch.last_in_order),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_total_cost   (out_ch.total_cost)
  );

endmodule

`default_nettype wire
